### sv/atc_pkg.sv
// Shared constants and types of the exponential target adjustment unit.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package atc_pkg;

	localparam int WordW  = 64;
	localparam int TgtW   = 256;
	localparam int HgtW   = 63;
	localparam int CfgW   = 32;
	localparam int ExpW   = 24;
	localparam int FracW  = 16;
	localparam int ShW    = 9;
	localparam int FacW   = 17;
	localparam int ErrW   = 98;
	localparam int ScW    = ErrW + FracW;
	localparam int RemW   = CfgW + ExpW;
	localparam int PpW    = 32 + FacW;
	localparam int BigW   = TgtW + FacW;
	localparam int DivSteps = ExpW;

	localparam logic [47:0]     PolyC1    = 48'd195766423245049;
	localparam logic [29:0]     PolyC2    = 30'd971821376;
	localparam logic [12:0]     PolyC3    = 13'd5127;
	localparam logic [63:0]     PolyRound = 64'h0000_8000_0000_0000;
	localparam logic [FacW-1:0] FactorOne = 17'd65536;

	localparam logic [CfgW-1:0] SpacingRst  = 32'd600;
	localparam logic [CfgW-1:0] HalfLifeRst = 32'd172800;
	localparam logic [TgtW-1:0] LimitRst    = {32'd0, {224{1'b1}}};

	typedef enum logic [2:0] {
		REG_SPACING   = 3'd0,
		REG_HALF_LIFE = 3'd1,
		REG_LIMIT0    = 3'd2,
		REG_LIMIT1    = 3'd3,
		REG_LIMIT2    = 3'd4,
		REG_LIMIT3    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic err;
		logic sat;
		logic eneg;
	} ctl_t;

	typedef struct packed {
		logic [TgtW-1:0] tgt;
		logic            err;
	} res_t;

endpackage

`default_nettype wire

### sv/atc_job_if.sv
// Input channel: a reference target, elapsed time and height difference.
// Depends on atc_pkg for the field widths.
`default_nettype none

interface atc_job_if;
	import atc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [WordW-1:0]         ref_word0;
	logic [WordW-1:0]         ref_word1;
	logic [WordW-1:0]         ref_word2;
	logic [WordW-1:0]         ref_word3;
	logic signed [WordW-1:0]  elapsed_time;
	logic [HgtW-1:0]          height_delta;

	modport source (output valid, ref_word0, ref_word1, ref_word2, ref_word3,
		elapsed_time, height_delta, input ready);
	modport sink (input valid, ref_word0, ref_word1, ref_word2, ref_word3,
		elapsed_time, height_delta, output ready);
endinterface

`default_nettype wire

### sv/atc_res_if.sv
// Output channel: the new target and the bad-reference flag.
// Depends on atc_pkg for the field widths.
`default_nettype none

interface atc_res_if;
	import atc_pkg::*;
	logic             valid;
	logic             ready;
	logic [WordW-1:0] new_word0;
	logic [WordW-1:0] new_word1;
	logic [WordW-1:0] new_word2;
	logic [WordW-1:0] new_word3;
	logic             input_error;

	modport source (output valid, new_word0, new_word1, new_word2, new_word3,
		input_error, input ready);
	modport sink (input valid, new_word0, new_word1, new_word2, new_word3,
		input_error, output ready);
endinterface

`default_nettype wire

### sv/asert_target_calculator.sv
// Channel  | Dir | Handshake      | Word
// job      | in  | valid/ready    | ref_word0..3, elapsed_time, height_delta
// result   | out | valid/ready    | new_word0..3, input_error
// apb      | in  | psel/penable   | registers at byte address 8*index, 64-bit data
//
// One word enters per cycle while the skid register is empty; its result is registered in the output register.
// The 24-step restoring divider, one quotient bit per stage, is most of the pipeline.
// Reset clears the valid bits and loads the register reset values.
// A stalled result waits in the output register; one more word lands in a skid
// register, and only then does the pipeline hold (bubbles are not squeezed out).
// Depends on atc_pkg, atc_job_if and atc_res_if.
`default_nettype none

module asert_target_calculator (
	input  logic                clk,
	input  logic                arst_n,
	atc_job_if.sink             job,
	atc_res_if.source           result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);
	import atc_pkg::*;

	localparam int LastSt = 38;

	// Configuration registers
	logic [CfgW-1:0] spacing_q;
	logic [CfgW-1:0] half_life_q;
	logic [TgtW-1:0] limit_q;
	logic [CfgW-1:0] hl;
	reg_idx_t        ridx;

	assign ridx   = reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;
	assign hl     = (half_life_q == '0) ? 32'd1 : half_life_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q   <= SpacingRst;
			half_life_q <= HalfLifeRst;
			limit_q     <= LimitRst;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_SPACING:   spacing_q <= pwdata[CfgW-1:0];
				REG_HALF_LIFE: half_life_q <= pwdata[CfgW-1:0];
				REG_LIMIT0:    limit_q[0*WordW +: WordW] <= pwdata;
				REG_LIMIT1:    limit_q[1*WordW +: WordW] <= pwdata;
				REG_LIMIT2:    limit_q[2*WordW +: WordW] <= pwdata;
				REG_LIMIT3:    limit_q[3*WordW +: WordW] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_SPACING:   prdata = {32'd0, spacing_q};
			REG_HALF_LIFE: prdata = {32'd0, half_life_q};
			REG_LIMIT0:    prdata = limit_q[0*WordW +: WordW];
			REG_LIMIT1:    prdata = limit_q[1*WordW +: WordW];
			REG_LIMIT2:    prdata = limit_q[2*WordW +: WordW];
			REG_LIMIT3:    prdata = limit_q[3*WordW +: WordW];
			default:       prdata = '0;
		endcase
	end

	// Pipeline control
	logic              en;
	logic [LastSt:1]   vld_q;
	logic              out_vld_q;
	logic              sk_vld_q;
	res_t              out_q;
	res_t              sk_q;
	res_t              res_c;

	assign en        = !sk_vld_q;
	assign job.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LastSt-1:1], job.valid};
		end
	end

	// Stage 1: input compare and the two halves of spacing * (height + 1)
	logic [TgtW-1:0]         ref_in;
	logic [WordW-1:0]        h1;
	logic [WordW-1:0]        p0_c, p1_c;
	logic [TgtW-1:0]         ref_s1;
	logic signed [WordW-1:0] tim_s1;
	logic [WordW-1:0]        p0_s1, p1_s1;
	logic                    err_s1;

	assign ref_in = {job.ref_word3, job.ref_word2, job.ref_word1, job.ref_word0};
	assign h1     = {1'b0, job.height_delta} + 64'd1;
	assign p0_c   = spacing_q * h1[31:0];
	assign p1_c   = spacing_q * h1[63:32];

	always_ff @(posedge clk) begin
		if (en) begin
			ref_s1 <= ref_in;
			tim_s1 <= job.elapsed_time;
			p0_s1  <= p0_c;
			p1_s1  <= p1_c;
			err_s1 <= (ref_in == '0) || (ref_in > limit_q);
		end
	end

	// Stage 2: scheduled time; stage 3: signed schedule error
	logic [95:0]             prod_s2;
	logic signed [WordW-1:0] tim_s2;
	logic [TgtW-1:0]         ref_s2, ref_s3, ref_s4, ref_s5;
	logic                    err_s2, err_s3;
	logic [ErrW-1:0]         diff_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= {p1_s1[63:0], 32'd0} + {32'd0, p0_s1};
			tim_s2  <= tim_s1;
			ref_s2  <= ref_s1;
			err_s2  <= err_s1;
			diff_s3 <= {{(ErrW-WordW){tim_s2[WordW-1]}}, tim_s2} - {2'b00, prod_s2};
			ref_s3  <= ref_s2;
			err_s3  <= err_s2;
		end
	end

	// Stage 4: magnitude scaled by 65536; stage 5: exponent range check
	logic [ScW-1:0]  sc_s4;
	logic [ErrW-1:0] mag_c;
	ctl_t            ctl_s4, ctl_s5;
	logic [RemW-1:0] rem_s5;

	assign mag_c = diff_s3[ErrW-1] ? (~diff_s3 + 98'd1) : diff_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s4       <= {mag_c, 16'd0};
			ctl_s4.err  <= err_s3;
			ctl_s4.sat  <= 1'b0;
			ctl_s4.eneg <= diff_s3[ErrW-1];
			ref_s4      <= ref_s3;
			rem_s5      <= sc_s4[RemW-1:0];
			ctl_s5.err  <= ctl_s4.err;
			ctl_s5.eneg <= ctl_s4.eneg;
			ctl_s5.sat  <= (|sc_s4[ScW-1:RemW]) || (sc_s4[RemW-1:0] >= {hl, 24'd0});
			ref_s5      <= ref_s4;
		end
	end

	// Stages 6 to 29: restoring division, one quotient bit per stage, msb first.
	// The range check guarantees the quotient fits in ExpW bits.
	logic [RemW-1:0] div_rem_s6 [DivSteps];
	logic [ExpW-1:0] div_q_s6   [DivSteps];
	logic [TgtW-1:0] div_ref_s6 [DivSteps];
	ctl_t            div_ctl_s6 [DivSteps];

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		logic [RemW-1:0] rem_in;
		logic [ExpW-1:0] q_in;
		logic [TgtW-1:0] ref_d;
		ctl_t            ctl_d;
		logic [RemW:0]   trial;

		if (j == 0) begin : g_first
			assign rem_in = rem_s5;
			assign q_in   = '0;
			assign ref_d  = ref_s5;
			assign ctl_d  = ctl_s5;
		end else begin : g_next
			assign rem_in = div_rem_s6[j-1];
			assign q_in   = div_q_s6[j-1];
			assign ref_d  = div_ref_s6[j-1];
			assign ctl_d  = div_ctl_s6[j-1];
		end

		assign trial = {1'b0, rem_in} - {1'b0, ({24'd0, hl} << (DivSteps-1-j))};

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s6[j] <= trial[RemW] ? rem_in : trial[RemW-1:0];
				div_q_s6[j]   <= trial[RemW] ? q_in : (q_in | (24'd1 << (DivSteps-1-j)));
				div_ref_s6[j] <= ref_d;
				div_ctl_s6[j] <= ctl_d;
			end
		end
	end

	// Stage 30: offset exponent, split into shift and fraction.
	// The window shift below equals the integer part of the offset exponent.
	logic [ExpW:0]   u_c;
	logic [FracW-1:0] fr_s30, fr_s31;
	logic [ShW-1:0]  sh_s30, sh_s31, sh_s32, sh_s33, sh_s34, sh_s35, sh_s36, sh_s37;
	ctl_t            ctl_s30, ctl_s31, ctl_s32, ctl_s33, ctl_s34, ctl_s35, ctl_s36;
	ctl_t            ctl_s37, ctl_s38;
	logic [TgtW-1:0] ref_s30, ref_s31, ref_s32, ref_s33, ref_s34;

	assign u_c = div_ctl_s6[DivSteps-1].eneg
		? ((25'd1 << ExpW) - {1'b0, div_q_s6[DivSteps-1]})
		: ((25'd1 << ExpW) + {1'b0, div_q_s6[DivSteps-1]});

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s30  <= u_c[FracW-1:0];
			sh_s30  <= u_c[ExpW:FracW];
			ctl_s30 <= div_ctl_s6[DivSteps-1];
			ref_s30 <= div_ref_s6[DivSteps-1];
		end
	end

	// Stages 31 to 34: cubic for 2^fraction, wrapping at 64 bits
	logic [31:0] fr2_s31, fr2_c;
	logic [47:0] fr3_s32, fr3_c;
	logic [63:0] ta_s31, ta_s32, tb_s32, tab_s33, tc_s33;
	logic [63:0] ta_c, tb_c, tc_c, poly_c;
	logic [FacW-1:0] fac_s34;

	assign fr2_c  = fr_s30 * fr_s30;
	assign ta_c   = PolyC1 * fr_s30;
	assign fr3_c  = fr2_s31 * fr_s31;
	assign tb_c   = PolyC2 * fr2_s31;
	assign tc_c   = PolyC3 * fr3_s32;
	assign poly_c = tab_s33 + tc_s33 + PolyRound;

	always_ff @(posedge clk) begin
		if (en) begin
			fr2_s31 <= fr2_c;
			ta_s31  <= ta_c;
			fr_s31  <= fr_s30;
			sh_s31  <= sh_s30;
			ctl_s31 <= ctl_s30;
			ref_s31 <= ref_s30;

			fr3_s32 <= fr3_c;
			tb_s32  <= tb_c;
			ta_s32  <= ta_s31;
			sh_s32  <= sh_s31;
			ctl_s32 <= ctl_s31;
			ref_s32 <= ref_s31;

			tc_s33  <= tc_c;
			tab_s33 <= ta_s32 + tb_s32;
			sh_s33  <= sh_s32;
			ctl_s33 <= ctl_s32;
			ref_s33 <= ref_s32;

			fac_s34 <= FactorOne + {1'b0, poly_c[63:48]};
			sh_s34  <= sh_s33;
			ctl_s34 <= ctl_s33;
			ref_s34 <= ref_s33;
		end
	end

	// Stage 35: eight 32 x 17 partial products; stage 36: their sum
	logic [PpW-1:0]  pp_s35 [8];
	logic [BigW-1:0] evn_c, odd_c, big_s36;

	always_comb begin
		evn_c = '0;
		odd_c = '0;
		for (int i = 0; i < 4; i++) begin
			evn_c[64*i +: PpW]      = pp_s35[2*i];
			odd_c[64*i + 32 +: PpW] = pp_s35[2*i+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				pp_s35[i] <= ref_s34[32*i +: 32] * fac_s34;
			end
			sh_s35  <= sh_s34;
			ctl_s35 <= ctl_s34;
			big_s36 <= evn_c + odd_c;
			sh_s36  <= sh_s35;
			ctl_s36 <= ctl_s35;
		end
	end

	// Stages 37 and 38: the product shifted left by the window shift, in two
	// steps; the new target is the part from bit 272 up of that word.
	localparam int W1W = BigW + 31;
	localparam int W2W = BigW + 511;
	logic [W1W-1:0]  w1_s37;
	logic [W2W-1:0]  w2_c;
	logic [TgtW-1:0] lo_s38;
	logic            hi_s38;

	assign w2_c = {{(W2W-W1W){1'b0}}, w1_s37} << {sh_s37[ShW-1:5], 5'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			w1_s37  <= {{(W1W-BigW){1'b0}}, big_s36} << sh_s36[4:0];
			sh_s37  <= sh_s36;
			ctl_s37 <= ctl_s36;
			hi_s38  <= |w2_c[W2W-1:BigW+TgtW-1];
			lo_s38  <= w2_c[BigW+TgtW-2:BigW-1];
			ctl_s38 <= ctl_s37;
		end
	end

	// Clamp and select the result
	always_comb begin
		res_c.err = ctl_s38.err;
		if (ctl_s38.err) begin
			res_c.tgt = '0;
		end else if (ctl_s38.sat) begin
			res_c.tgt = ctl_s38.eneg ? 256'd1 : limit_q;
		end else if ((lo_s38 == '0) && !hi_s38) begin
			res_c.tgt = 256'd1;
		end else if (hi_s38 || (lo_s38 > limit_q)) begin
			res_c.tgt = limit_q;
		end else begin
			res_c.tgt = lo_s38;
		end
	end

	// Output register and skid register
	logic out_free;
	logic take;

	assign out_free = !out_vld_q || result.ready;
	assign take     = en && vld_q[LastSt];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= sk_vld_q || take;
			sk_vld_q  <= 1'b0;
		end else if (take) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= sk_vld_q ? sk_q : res_c;
		end else if (take) begin
			sk_q <= res_c;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.new_word0   = out_q.tgt[0*WordW +: WordW];
	assign result.new_word1   = out_q.tgt[1*WordW +: WordW];
	assign result.new_word2   = out_q.tgt[2*WordW +: WordW];
	assign result.new_word3   = out_q.tgt[3*WordW +: WordW];
	assign result.input_error = out_q.err;

`ifndef SYNTH
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.input_error |->
		(result.new_word0 == '0) && (result.new_word1 == '0) &&
		(result.new_word2 == '0) && (result.new_word3 == '0))
		else $error("flagged word carries a nonzero target");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.input_error |->
		((result.new_word0 | result.new_word1 | result.new_word2 | result.new_word3) != '0))
		else $error("accepted reference produced a zero target");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		sk_vld_q |-> out_vld_q)
		else $error("skid register full while output register is empty");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid && job.ready |=> vld_q[1])
		else $error("accepted word did not enter the first stage");
`endif

endmodule

`default_nettype wire
